[design/cscm_pkg.sv]
package cscm_pkg;

   localparam int MODE_W      = 2;
   localparam int SYMBOL_W    = 2;
   localparam int FREQ_W      = 33;
   localparam int TOTAL_W     = 35;
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CFG_W-1:0] COUNT_LIMIT_RESET = 16'hFFFF;
   localparam logic [CFG_W-1:0] FREQ_OFFSET_RESET = 16'd1;
   localparam logic [CFG_W-1:0] FREQ_GAIN_RESET   = 16'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COUNT_LIMIT = 2'd0,
      CSR_FREQ_OFFSET = 2'd1,
      CSR_FREQ_GAIN   = 2'd2
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      OP_UPDATE  = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_COMPUTE = 2'd2
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SYMBOL_W-1:0] symbol;
      logic                sym_ok;
   } cmd_type;

   typedef struct packed {
      logic [CFG_W-1:0] count_limit;
      logic [CFG_W-1:0] freq_offset;
      logic [CFG_W-1:0] freq_gain;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } back_state_type;

endpackage

[design/cscm_front.sv]
module cscm_front #(
   parameter int NUM_SYMBOLS  = 4,
   parameter int CONTEXT_BITS = 12
) (
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [cscm_pkg::MODE_W-1:0]            req_mode,
   input  logic [CONTEXT_BITS-1:0]                req_context_index,
   input  logic [cscm_pkg::SYMBOL_W-1:0]          req_symbol,
   input  cscm_pkg::queue_status_type             queue_status,
   input  cscm_pkg::back_status_type              back_status,
   output logic                                   push,
   output logic [$bits(cscm_pkg::cmd_type)+CONTEXT_BITS-1:0] push_data
);

   cscm_pkg::cmd_type cmd;
   logic              keep;

   always_comb begin
      cmd.op     = cscm_pkg::OP_UPDATE;
      cmd.symbol = req_symbol;
      cmd.sym_ok = (32'(req_symbol) < NUM_SYMBOLS);
      keep       = 1'b1;
      unique case (req_mode)
         cscm_pkg::OP_UPDATE:  cmd.op = cscm_pkg::OP_UPDATE;
         cscm_pkg::OP_REMOVE:  cmd.op = cscm_pkg::OP_REMOVE;
         cscm_pkg::OP_COMPUTE: cmd.op = cscm_pkg::OP_COMPUTE;
         // unused mode: taken off the channel, nothing queued
         default:              keep   = 1'b0;
      endcase
   end

   assign req_ready = !queue_status.full && !back_status.clearing;
   assign push      = req_valid && req_ready && keep;
   assign push_data = {cmd, req_context_index};

endmodule

[design/cscm_queue.sv]
module cscm_queue #(
   parameter int WIDTH = 17
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           head_data,
   output cscm_pkg::queue_status_type status
);

   localparam int PTR_W = (cscm_pkg::QUEUE_DEPTH > 1) ? $clog2(cscm_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(cscm_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [cscm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(cscm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(cscm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(cscm_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[design/cscm_back.sv]
module cscm_back #(
   parameter int NUM_SYMBOLS  = 4,
   parameter int CONTEXT_BITS = 12,
   parameter int COUNTER_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cscm_pkg::cfg_type                   cfg,
   input  cscm_pkg::queue_status_type          queue_status,
   input  cscm_pkg::cmd_type                   head_cmd,
   input  logic [CONTEXT_BITS-1:0]             head_ctx,
   output logic                                pop,
   output cscm_pkg::back_status_type           back_status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cscm_pkg::SYMBOL_W-1:0]       rsp_symbol_index,
   output logic [cscm_pkg::FREQ_W-1:0]         rsp_frequency,
   output logic [cscm_pkg::TOTAL_W-1:0]        rsp_total,
   output logic                                rsp_error,
   output logic                                rsp_last
);

   localparam int NUM_CONTEXTS = 2 ** CONTEXT_BITS;
   localparam int SYM_IDX_W    = $clog2(NUM_SYMBOLS);
   localparam int PROD_W       = cscm_pkg::CFG_W + COUNTER_BITS;
   localparam int CMP_W        = (COUNTER_BITS > cscm_pkg::CFG_W) ? COUNTER_BITS : cscm_pkg::CFG_W;

   typedef logic [NUM_SYMBOLS-1:0][COUNTER_BITS-1:0] row_type;

   // one row holds every counter of a context
   row_type mem [NUM_CONTEXTS];
   row_type rd_data_ff;
   logic                    rd_en, wr_en;
   logic [CONTEXT_BITS-1:0] rd_addr, wr_addr;
   row_type                 wr_data;

   cscm_pkg::back_state_type state_ff, state_in;
   logic [CONTEXT_BITS-1:0]  clr_addr_ff, clr_addr_in;
   cscm_pkg::cmd_type        cmd_ff, cmd_in;
   logic [CONTEXT_BITS-1:0]  ctx_ff, ctx_in;
   logic [SYM_IDX_W-1:0]     idx_ff, idx_in;
   logic [cscm_pkg::TOTAL_W-1:0] prod_ff, prod_in;
   logic [cscm_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [cscm_pkg::SYMBOL_W-1:0]     rsp_symbol_ff, rsp_symbol_in;
   logic [cscm_pkg::FREQ_W-1:0]       rsp_freq_ff, rsp_freq_in;
   logic [cscm_pkg::TOTAL_W-1:0]      rsp_total_ff, rsp_total_in;
   logic                              rsp_error_ff, rsp_error_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                         slot_free;
   logic [SYM_IDX_W-1:0]         sym_idx;
   logic [COUNTER_BITS-1:0]      cur_cnt, inc_cnt, upd_val;
   logic                         halve, rem_ok, idx_last;
   row_type                      upd_row, rem_row;
   logic [SYM_IDX_W-1:0]         mul_idx;
   logic [PROD_W-1:0]            prod_full;
   logic [cscm_pkg::TOTAL_W-1:0] freq_full, total_next;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign sym_idx   = SYM_IDX_W'(cmd_ff.symbol);
   assign cur_cnt   = rd_data_ff[sym_idx];
   assign inc_cnt   = cur_cnt + 1'b1;
   assign halve     = (cfg.count_limit != '0) && (CMP_W'(inc_cnt) == CMP_W'(cfg.count_limit));
   assign rem_ok    = cmd_ff.sym_ok && (cur_cnt != '0);
   assign idx_last  = (idx_ff == SYM_IDX_W'(NUM_SYMBOLS - 1));

   always_comb begin
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
         upd_val    = (SYM_IDX_W'(s) == sym_idx) ? inc_cnt : rd_data_ff[s];
         upd_row[s] = halve ? (upd_val >> 1) : upd_val;
         rem_row[s] = (SYM_IDX_W'(s) == sym_idx) ? cur_cnt - 1'b1 : rd_data_ff[s];
      end
   end

   assign prod_full  = PROD_W'(cfg.freq_gain) * PROD_W'(rd_data_ff[mul_idx]);
   // frequency kept to total width so the running sum sees the whole value
   assign freq_full  = cscm_pkg::TOTAL_W'(cfg.freq_offset) + prod_ff;
   assign total_next = total_ff + freq_full;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      cmd_in        = cmd_ff;
      ctx_in        = ctx_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      total_in      = total_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = head_ctx;
      wr_en         = 1'b0;
      wr_addr       = ctx_ff;
      wr_data       = upd_row;
      mul_idx       = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_error_in  = rsp_error_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         cscm_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = cscm_pkg::ST_IDLE;
            end
         end
         cscm_pkg::ST_IDLE: begin
            if (!queue_status.empty) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               cmd_in   = head_cmd;
               ctx_in   = head_ctx;
               state_in = cscm_pkg::ST_EXEC;
            end
         end
         cscm_pkg::ST_EXEC: begin
            case (cmd_ff.op)
               cscm_pkg::OP_UPDATE: begin
                  wr_en    = cmd_ff.sym_ok;
                  state_in = cscm_pkg::ST_IDLE;
               end
               cscm_pkg::OP_REMOVE: begin
                  if (slot_free) begin
                     wr_en         = rem_ok;
                     wr_data       = rem_row;
                     rsp_valid_in  = 1'b1;
                     rsp_symbol_in = cmd_ff.symbol;
                     rsp_freq_in   = '0;
                     rsp_total_in  = '0;
                     rsp_error_in  = !rem_ok;
                     rsp_last_in   = 1'b1;
                     state_in      = cscm_pkg::ST_IDLE;
                  end
               end
               cscm_pkg::OP_COMPUTE: begin
                  mul_idx  = '0;
                  prod_in  = cscm_pkg::TOTAL_W'(prod_full);
                  idx_in   = '0;
                  total_in = '0;
                  state_in = cscm_pkg::ST_EMIT;
               end
               default: state_in = cscm_pkg::ST_IDLE;
            endcase
         end
         cscm_pkg::ST_EMIT: begin
            // one symbol per cycle while the result slot is free: emit this one, multiply the next
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = cscm_pkg::SYMBOL_W'(idx_ff);
               rsp_freq_in   = freq_full[cscm_pkg::FREQ_W-1:0];
               rsp_total_in  = total_next;
               rsp_error_in  = 1'b0;
               rsp_last_in   = idx_last;
               total_in      = total_next;
               if (idx_last) begin
                  state_in = cscm_pkg::ST_IDLE;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  mul_idx = idx_ff + 1'b1;
                  prod_in = cscm_pkg::TOTAL_W'(prod_full);
               end
            end
         end
         default: state_in = cscm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cscm_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ctx_ff        <= ctx_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      total_ff      <= total_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_error_ff  <= rsp_error_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign back_status.clearing = (state_ff == cscm_pkg::ST_CLEAR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol_index = rsp_symbol_ff;
   assign rsp_frequency    = rsp_freq_ff;
   assign rsp_total        = rsp_total_ff;
   assign rsp_error        = rsp_error_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

[design/context_symbol_counter_model.sv]
// Per-context symbol counter table. After reset the counter store is swept to
// zero, one context row per cycle, with req_ready low; CSR writes are taken
// throughout. A two-entry queue sits between the request side and the
// execution side, so requests keep being taken while a result waits on rsp.
// Execution handles one request at a time as a read-modify-write of the
// context's counter row: remove waits for the output register to be free,
// compute gives one result per cycle while the output register is free, from
// a single gain multiplier. Requests with the unused mode are taken and
// dropped. CSRs may be written only while no request is in flight.
module context_symbol_counter_model #(
   parameter int NUM_SYMBOLS  = 4,
   parameter int CONTEXT_BITS = 12,
   parameter int COUNTER_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cscm_pkg::MODE_W-1:0]         req_mode,
   input  logic [CONTEXT_BITS-1:0]             req_context_index,
   input  logic [cscm_pkg::SYMBOL_W-1:0]       req_symbol,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cscm_pkg::SYMBOL_W-1:0]       rsp_symbol_index,
   output logic [cscm_pkg::FREQ_W-1:0]         rsp_frequency,
   output logic [cscm_pkg::TOTAL_W-1:0]        rsp_total,
   output logic                                rsp_error,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cscm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cscm_pkg::CFG_W-1:0]          csr_data
);

   localparam int QW = $bits(cscm_pkg::cmd_type) + CONTEXT_BITS;

   cscm_pkg::cfg_type          cfg_ff, cfg_in;
   cscm_pkg::queue_status_type queue_status;
   cscm_pkg::back_status_type  back_status;
   cscm_pkg::cmd_type          head_cmd;
   logic [CONTEXT_BITS-1:0]    head_ctx;
   logic [QW-1:0]              push_data, head_data;
   logic                       push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cscm_pkg::CSR_COUNT_LIMIT: cfg_in.count_limit = csr_data;
            cscm_pkg::CSR_FREQ_OFFSET: cfg_in.freq_offset = csr_data;
            cscm_pkg::CSR_FREQ_GAIN:   cfg_in.freq_gain   = csr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_limit <= cscm_pkg::COUNT_LIMIT_RESET;
         cfg_ff.freq_offset <= cscm_pkg::FREQ_OFFSET_RESET;
         cfg_ff.freq_gain   <= cscm_pkg::FREQ_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cscm_front #(
      .NUM_SYMBOLS  (NUM_SYMBOLS),
      .CONTEXT_BITS (CONTEXT_BITS)
   ) u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_context_index (req_context_index),
      .req_symbol        (req_symbol),
      .queue_status      (queue_status),
      .back_status       (back_status),
      .push              (push),
      .push_data         (push_data)
   );

   cscm_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   assign {head_cmd, head_ctx} = head_data;

   cscm_back #(
      .NUM_SYMBOLS  (NUM_SYMBOLS),
      .CONTEXT_BITS (CONTEXT_BITS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .queue_status     (queue_status),
      .head_cmd         (head_cmd),
      .head_ctx         (head_ctx),
      .pop              (pop),
      .back_status      (back_status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol_index (rsp_symbol_index),
      .rsp_frequency    (rsp_frequency),
      .rsp_total        (rsp_total),
      .rsp_error        (rsp_error),
      .rsp_last         (rsp_last)
   );

endmodule

[design/cscm_checker.sv]
module cscm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cscm_pkg::SYMBOL_W-1:0] rsp_symbol_index,
   input logic [cscm_pkg::FREQ_W-1:0]   rsp_frequency,
   input logic [cscm_pkg::TOTAL_W-1:0]  rsp_total,
   input logic                          rsp_error,
   input logic                          rsp_last
);

   // store is being cleared straight after reset
   a_no_req_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during store clear");

   a_error_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && rsp_frequency == '0 && rsp_total == '0)
      else $error("error result not a lone zero transfer");

   a_error_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !rsp_error)
      else $error("error flagged inside a frequency sequence");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_symbol_index, rsp_frequency, rsp_total, rsp_error, rsp_last}))
      else $error("stalled result changed");

endmodule

bind context_symbol_counter_model cscm_checker u_cscm_checker (.*);

[sim/context_symbol_counter_model_check.sv]
`timescale 1ns / 100ps

module context_symbol_counter_model_check (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   input  logic                                       req_ready,
   input  logic [cscm_pkg::MODE_W-1:0]                req_mode,
   input  logic [11:0]                                req_context_index,
   input  logic [cscm_pkg::SYMBOL_W-1:0]              req_symbol,
   input  logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   input  logic [cscm_pkg::SYMBOL_W-1:0]              rsp_symbol_index,
   input  logic [cscm_pkg::FREQ_W-1:0]                rsp_frequency,
   input  logic [cscm_pkg::TOTAL_W-1:0]               rsp_total,
   input  logic                                       rsp_error,
   input  logic                                       rsp_last,
   input  logic                                       csr_valid,
   input  logic                                       csr_ready,
   input  logic [cscm_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [cscm_pkg::CFG_W-1:0]                 csr_data,
   output int unsigned                                fault_count,
   output int unsigned                                results_owed,
   output int unsigned                                results_seen
);

   localparam int SYMBOLS   = 4;
   localparam int CONTEXTS  = 4096;
   localparam int COUNTER_W = 16;

   typedef struct packed {
      logic [cscm_pkg::SYMBOL_W-1:0] symbol_index;
      logic [cscm_pkg::FREQ_W-1:0]   frequency;
      logic [cscm_pkg::TOTAL_W-1:0]  total;
      logic                          error;
      logic                          last;
   } freq_result_type;

   logic [COUNTER_W-1:0] tally [0:CONTEXTS*SYMBOLS-1];
   cscm_pkg::cfg_type    setting;
   freq_result_type      owed [$];
   freq_result_type      want;

   task automatic predict_request(input logic [cscm_pkg::MODE_W-1:0] mode,
                                  input logic [11:0] row_index,
                                  input logic [cscm_pkg::SYMBOL_W-1:0] sym);
      int unsigned                  row;
      logic [COUNTER_W-1:0]         next_count;
      logic [cscm_pkg::FREQ_W-1:0]  wide_gain;
      logic [cscm_pkg::FREQ_W-1:0]  wide_count;
      logic [cscm_pkg::TOTAL_W-1:0] sum;
      freq_result_type              r;
      row = row_index * SYMBOLS;
      case (mode)
         cscm_pkg::OP_UPDATE: begin
            next_count = tally[row + sym] + 1'b1;
            tally[row + sym] = next_count;
            // hitting a nonzero limit halves the whole context row
            if (setting.count_limit != '0 && next_count == setting.count_limit)
               for (int s = 0; s < SYMBOLS; s++)
                  tally[row + s] = tally[row + s] >> 1;
         end
         cscm_pkg::OP_REMOVE: begin
            r = '0;
            r.symbol_index = sym;
            r.last = 1'b1;
            if (tally[row + sym] != '0)
               tally[row + sym] = tally[row + sym] - 1'b1;
            else
               r.error = 1'b1;
            owed.push_back(r);
         end
         cscm_pkg::OP_COMPUTE: begin
            sum = '0;
            wide_gain = cscm_pkg::FREQ_W'(setting.freq_gain);
            for (int s = 0; s < SYMBOLS; s++) begin
               r = '0;
               wide_count = cscm_pkg::FREQ_W'(tally[row + s]);
               r.symbol_index = s[cscm_pkg::SYMBOL_W-1:0];
               r.frequency = setting.freq_offset + wide_gain * wide_count;
               sum = sum + r.frequency;
               r.total = sum;
               r.last = (s == SYMBOLS - 1);
               owed.push_back(r);
            end
         end
         default: ; // unused mode is swallowed
      endcase
   endtask

   task automatic note_field(input string field,
                             input logic [cscm_pkg::TOTAL_W-1:0] expected_value,
                             input logic [cscm_pkg::TOTAL_W-1:0] actual_value);
      if (expected_value !== actual_value) begin
         fault_count++;
         $error("%s mismatch: expected %0d, got %0d", field, expected_value, actual_value);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CONTEXTS*SYMBOLS; i++)
            tally[i] = '0;
         setting.count_limit = cscm_pkg::COUNT_LIMIT_RESET;
         setting.freq_offset = cscm_pkg::FREQ_OFFSET_RESET;
         setting.freq_gain   = cscm_pkg::FREQ_GAIN_RESET;
         owed.delete();
         fault_count  = 0;
         results_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cscm_pkg::CSR_COUNT_LIMIT: setting.count_limit = csr_data;
               cscm_pkg::CSR_FREQ_OFFSET: setting.freq_offset = csr_data;
               cscm_pkg::CSR_FREQ_GAIN:   setting.freq_gain   = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_request(req_mode, req_context_index, req_symbol);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (owed.size() == 0) begin
               fault_count++;
               $error("unexpected result transfer: symbol_index %0d frequency %0d total %0d",
                      rsp_symbol_index, rsp_frequency, rsp_total);
            end else begin
               want = owed.pop_front();
               note_field("symbol_index", cscm_pkg::TOTAL_W'(want.symbol_index),
                          cscm_pkg::TOTAL_W'(rsp_symbol_index));
               note_field("frequency", cscm_pkg::TOTAL_W'(want.frequency),
                          cscm_pkg::TOTAL_W'(rsp_frequency));
               note_field("total", want.total, rsp_total);
               note_field("error", cscm_pkg::TOTAL_W'(want.error),
                          cscm_pkg::TOTAL_W'(rsp_error));
               note_field("last", cscm_pkg::TOTAL_W'(want.last),
                          cscm_pkg::TOTAL_W'(rsp_last));
            end
         end
      end
      results_owed = owed.size();
   end

endmodule

[sim/context_symbol_counter_model_test.sv]
`timescale 1ns / 100ps

module context_symbol_counter_model_test;

   localparam int CONTEXT_BITS   = 12;
   localparam int WATCHDOG_LIMIT = 16384;
   localparam int SETTLE_CYCLES  = 24;
   localparam int PHASE_ITEMS    = 24;
   localparam logic [cscm_pkg::MODE_W-1:0] MODE_UNUSED  = 2'd3;
   localparam logic [CONTEXT_BITS-1:0]     WRAP_CONTEXT = 12'h3C5;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [cscm_pkg::MODE_W-1:0]      req_mode;
   logic [CONTEXT_BITS-1:0]          req_context_index;
   logic [cscm_pkg::SYMBOL_W-1:0]    req_symbol;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [cscm_pkg::SYMBOL_W-1:0]    rsp_symbol_index;
   logic [cscm_pkg::FREQ_W-1:0]      rsp_frequency;
   logic [cscm_pkg::TOTAL_W-1:0]     rsp_total;
   logic                             rsp_error;
   logic                             rsp_last;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [cscm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cscm_pkg::CFG_W-1:0]       csr_data;

   int unsigned             fault_count;
   int unsigned             results_owed;
   int unsigned             results_seen;
   int unsigned             sent_by_mode [0:3];
   int unsigned             settings_used;
   int unsigned             rsp_hold;
   int unsigned             idle_cycles;
   bit                      quiet;
   logic [CONTEXT_BITS-1:0] hot_rows [0:7];

   context_symbol_counter_model dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_context_index (req_context_index),
      .req_symbol        (req_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_symbol_index  (rsp_symbol_index),
      .rsp_frequency     (rsp_frequency),
      .rsp_total         (rsp_total),
      .rsp_error         (rsp_error),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   context_symbol_counter_model_check check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_context_index (req_context_index),
      .req_symbol        (req_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_symbol_index  (rsp_symbol_index),
      .rsp_frequency     (rsp_frequency),
      .rsp_total         (rsp_total),
      .rsp_error         (rsp_error),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fault_count       (fault_count),
      .results_owed      (results_owed),
      .results_seen      (results_seen)
   );

   initial clock = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_hold  <= $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $error("no transfer for %0d cycles, %0d results still owed", idle_cycles, results_owed);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_request(input logic [cscm_pkg::MODE_W-1:0] mode,
                               input logic [CONTEXT_BITS-1:0] row_index,
                               input logic [cscm_pkg::SYMBOL_W-1:0] sym);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_context_index <= row_index;
      req_symbol        <= sym;
      do @(posedge clock); while (!req_ready);
      sent_by_mode[mode]++;
   endtask

   task automatic write_register(input cscm_pkg::csr_index_type idx,
                                 input logic [cscm_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_settings(input logic [cscm_pkg::CFG_W-1:0] limit,
                                 input logic [cscm_pkg::CFG_W-1:0] offset,
                                 input logic [cscm_pkg::CFG_W-1:0] gain);
      write_register(cscm_pkg::CSR_COUNT_LIMIT, limit);
      write_register(cscm_pkg::CSR_FREQ_OFFSET, offset);
      write_register(cscm_pkg::CSR_FREQ_GAIN, gain);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // updates leave nothing to wait for, so give the pipe time to empty as well
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CONTEXT_BITS-1:0] pick_context();
      if ($urandom_range(0, 7) == 0)
         return CONTEXT_BITS'($urandom_range(0, 4095));
      return hot_rows[$urandom_range(0, 7)];
   endfunction

   task automatic random_phase(input int unsigned count);
      int unsigned                 pick;
      logic [cscm_pkg::MODE_W-1:0] mode;
      repeat (count) begin
         pick = $urandom_range(0, 19);
         if (pick < 10)
            mode = cscm_pkg::OP_UPDATE;
         else if (pick < 14)
            mode = cscm_pkg::OP_REMOVE;
         else if (pick < 19)
            mode = cscm_pkg::OP_COMPUTE;
         else
            mode = MODE_UNUSED;
         send_request(mode, pick_context(), cscm_pkg::SYMBOL_W'($urandom_range(0, 3)));
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_mode          = cscm_pkg::OP_UPDATE;
      req_context_index = '0;
      req_symbol        = '0;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = cscm_pkg::CSR_COUNT_LIMIT;
      csr_data          = '0;
      quiet             = 1'b0;
      rsp_hold          = 0;
      idle_cycles       = 0;
      settings_used     = 1;
      foreach (hot_rows[i])
         hot_rows[i] = CONTEXT_BITS'($urandom_range(0, 4095));
      hot_rows[0] = '0;
      hot_rows[1] = '1;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset settings: empty store, remove on zero, unused mode
      send_request(cscm_pkg::OP_COMPUTE, 12'h000, 2'd0);
      send_request(cscm_pkg::OP_REMOVE, 12'h000, 2'd0);
      send_request(cscm_pkg::OP_UPDATE, 12'hFFF, 2'd3);
      send_request(cscm_pkg::OP_UPDATE, 12'hFFF, 2'd3);
      send_request(cscm_pkg::OP_COMPUTE, 12'hFFF, 2'd1);
      send_request(cscm_pkg::OP_REMOVE, 12'hFFF, 2'd3);
      send_request(cscm_pkg::OP_COMPUTE, 12'hFFF, 2'd2);
      send_request(MODE_UNUSED, 12'h555, 2'd2);
      send_request(cscm_pkg::OP_COMPUTE, 12'h555, 2'd3);

      // small limit with full-scale weights: halving of a whole row
      drain_block();
      write_settings(16'd3, 16'hFFFF, 16'hFFFF);
      send_request(cscm_pkg::OP_UPDATE, 12'hAAA, 2'd1);
      send_request(cscm_pkg::OP_UPDATE, 12'hAAA, 2'd1);
      send_request(cscm_pkg::OP_UPDATE, 12'hAAA, 2'd2);
      send_request(cscm_pkg::OP_UPDATE, 12'hAAA, 2'd0);
      send_request(cscm_pkg::OP_COMPUTE, 12'hAAA, 2'd0);
      send_request(cscm_pkg::OP_UPDATE, 12'hAAA, 2'd1);
      send_request(cscm_pkg::OP_COMPUTE, 12'hAAA, 2'd1);
      send_request(cscm_pkg::OP_REMOVE, 12'hAAA, 2'd2);
      send_request(cscm_pkg::OP_REMOVE, 12'hAAA, 2'd1);
      send_request(cscm_pkg::OP_COMPUTE, 12'hAAA, 2'd3);

      drain_block();
      write_settings(16'd1, 16'd0, 16'd0);
      random_phase(PHASE_ITEMS);

      drain_block();
      write_settings(cscm_pkg::CFG_W'($urandom_range(2, 6)), cscm_pkg::CFG_W'($urandom),
                     cscm_pkg::CFG_W'($urandom));
      random_phase(PHASE_ITEMS);

      drain_block();
      write_settings(16'd0, cscm_pkg::CFG_W'($urandom), cscm_pkg::CFG_W'($urandom));
      random_phase(PHASE_ITEMS);

      // halving off: repeated updates of one counter with full-scale weights
      drain_block();
      quiet = 1'b1;
      write_settings(16'd0, 16'hFFFF, 16'hFFFF);
      repeat (4) send_request(cscm_pkg::OP_UPDATE, WRAP_CONTEXT, 2'd0);
      send_request(cscm_pkg::OP_COMPUTE, WRAP_CONTEXT, 2'd0);
      send_request(cscm_pkg::OP_UPDATE, WRAP_CONTEXT, 2'd0);
      send_request(cscm_pkg::OP_COMPUTE, WRAP_CONTEXT, 2'd3);
      send_request(cscm_pkg::OP_REMOVE, WRAP_CONTEXT, 2'd0);

      drain_block();
      write_settings(16'hFFFF, cscm_pkg::CFG_W'($urandom), cscm_pkg::CFG_W'($urandom));
      random_phase(PHASE_ITEMS);

      drain_block();
      $display("Requests: %0d update, %0d remove, %0d compute, %0d unused mode; %0d results",
               sent_by_mode[cscm_pkg::OP_UPDATE], sent_by_mode[cscm_pkg::OP_REMOVE],
               sent_by_mode[cscm_pkg::OP_COMPUTE], sent_by_mode[MODE_UNUSED], results_seen);
      $display("Register settings used: %0d, limit from 0 to full scale, halving on and off",
               settings_used);
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
